// ===== rtl/rrts_pkg.sv =====
// rrts_pkg: shared types and codes for the round-robin task scheduler.
// No dependencies; imported by the control, task table and top-level modules.
`default_nettype none

package rrts_pkg;

  // action codes of an input request
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  localparam int QUANTUM_W    = 8;
  localparam int TASK_ID_W    = 8;
  localparam int BURST_W      = 16;
  localparam int ACT_COUNT_W  = 5;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd4;

  typedef struct packed {
    logic                 action;
    logic [TASK_ID_W-1:0] task_id;
    logic [BURST_W-1:0]   burst_length;
  } item_t;

  typedef struct packed {
    logic                   ran;
    logic [TASK_ID_W-1:0]   ran_id;
    logic [BURST_W-1:0]     remaining_after;
    logic                   finished;
    logic                   add_accepted;
    logic [ACT_COUNT_W-1:0] active_count;
  } res_t;

  // table update for one request; at most one flag is set
  typedef struct packed {
    logic append;
    logic decrement;
    logic remove;
  } tbl_op_t;

endpackage

`default_nettype wire

// ===== rtl/rrts_ifs.sv =====
// rrts_ifs: valid/ready stream interfaces for the scheduler's request and
// result channels. Widths follow the fixed field widths of rrts_pkg.
`default_nettype none

interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  task_id;
  logic [15:0] burst_length;

  modport source (output valid, action, task_id, burst_length, input ready);
  modport sink   (input valid, action, task_id, burst_length, output ready);
endinterface

interface rrts_out_if;
  logic        valid;
  logic        ready;
  logic        ran;
  logic [7:0]  ran_id;
  logic [15:0] remaining_after;
  logic        finished;
  logic        add_accepted;
  logic [4:0]  active_count;

  modport source (output valid, ran, ran_id, remaining_after, finished, add_accepted,
                  active_count, input ready);
  modport sink   (input valid, ran, ran_id, remaining_after, finished, add_accepted,
                  active_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrts_task_table.sv =====
// rrts_task_table: task id / remaining-time queue in arrival order, with
// tail append, in-place decrement and gap closing on removal, where every
// later entry shifts down one slot. Depends on rrts_pkg (tbl_op_t).
`default_nettype none

module rrts_task_table
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic                         clk,
  input  wire tbl_op_t                      op,
  input  wire logic [$clog2(MAX_TASKS)-1:0] rd_pos,
  input  wire logic [$clog2(MAX_TASKS)-1:0] tail,
  input  wire logic [TASK_ID_W-1:0]         wr_id,
  input  wire logic [TIME_BITS-1:0]         wr_rem,
  output logic      [TASK_ID_W-1:0]         rd_id,
  output logic      [TIME_BITS-1:0]         rd_rem
);

  localparam int IDX_W = $clog2(MAX_TASKS);

  // entries at or above the task count hold stale data and are never read
  logic [TASK_ID_W-1:0] ids_r [MAX_TASKS];
  logic [TIME_BITS-1:0] rem_r [MAX_TASKS];

  assign rd_id  = ids_r[rd_pos];
  assign rd_rem = rem_r[rd_pos];

  always_ff @(posedge clk) begin
    if (op.append) begin
      ids_r[tail] <= wr_id;
      rem_r[tail] <= wr_rem;
    end
    if (op.decrement) begin
      rem_r[rd_pos] <= wr_rem;
    end
    if (op.remove) begin
      for (int i = 0; i < MAX_TASKS - 1; i++) begin
        if (IDX_W'(i) >= rd_pos) begin
          ids_r[i] <= ids_r[i+1];
          rem_r[i] <= rem_r[i+1];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrts_sched_ctrl.sv =====
// rrts_sched_ctrl: scheduler state (count, position, slice counter, quantum)
// and the single-pass decision for one request. Drives rrts_task_table.
// Depends on rrts_pkg.
`default_nettype none

module rrts_sched_ctrl
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [QUANTUM_W-1:0]         cfg_wr_data,
  input  wire logic                         go,
  input  wire item_t                        item,
  input  wire logic [TASK_ID_W-1:0]         rd_id,
  input  wire logic [TIME_BITS-1:0]         rd_rem,
  output tbl_op_t                           op,
  output logic      [$clog2(MAX_TASKS)-1:0] rd_pos,
  output logic      [$clog2(MAX_TASKS)-1:0] tail,
  output logic      [TASK_ID_W-1:0]         wr_id,
  output logic      [TIME_BITS-1:0]         wr_rem,
  output res_t                              res
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [QUANTUM_W-1:0] quantum_r;
  logic [CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic [IDX_W-1:0]     pos_r,   pos_nxt;
  logic [QUANTUM_W-1:0] slice_r, slice_nxt;

  logic [IDX_W-1:0]           p;
  logic [CNT_W-1:0]           cnt_dec;
  logic [QUANTUM_W-1:0]       slice_inc;
  logic [TIME_BITS-1:0]       rem_dec;
  logic [TIME_BITS+BURST_W-1:0] burst_ext;
  logic [TIME_BITS+BURST_W-1:0] rem_ext;
  logic [CNT_W+ACT_COUNT_W-1:0] cnt_ext;
  logic [TIME_BITS-1:0]       burst;

  assign p         = (CNT_W'(pos_r) >= cnt_r) ? '0 : pos_r;
  assign cnt_dec   = cnt_r - CNT_ONE;
  assign slice_inc = slice_r + QUANTUM_W'(1);
  assign rem_dec   = rd_rem - TIME_BITS'(1);
  assign burst_ext = {{TIME_BITS{1'b0}}, item.burst_length};
  assign burst     = burst_ext[TIME_BITS-1:0];
  assign rem_ext   = {{BURST_W{1'b0}}, rem_dec};
  assign cnt_ext   = {{ACT_COUNT_W{1'b0}}, cnt_nxt};

  assign rd_pos = p;
  assign tail   = cnt_r[IDX_W-1:0];
  assign wr_id  = item.task_id;
  assign wr_rem = (item.action == ACT_ADD) ? burst : rem_dec;

  always_comb begin
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    slice_nxt = slice_r;
    op        = '0;
    res       = '0;
    if (go) begin
      if (item.action == ACT_ADD) begin
        if (cnt_r < CNT_MAX && burst != '0) begin
          if (cnt_r == '0) begin
            pos_nxt   = '0;
            slice_nxt = '0;
          end
          op.append        = 1'b1;
          cnt_nxt          = cnt_r + CNT_ONE;
          res.add_accepted = 1'b1;
        end
      end else if (cnt_r != '0) begin
        res.ran             = 1'b1;
        res.ran_id          = rd_id;
        res.remaining_after = rem_ext[BURST_W-1:0];
        if (rem_dec == '0) begin
          // task done: close the gap, the successor takes this slot
          res.finished = 1'b1;
          op.remove    = 1'b1;
          cnt_nxt      = cnt_dec;
          slice_nxt    = '0;
          pos_nxt      = (CNT_W'(p) >= cnt_dec) ? '0 : p;
        end else begin
          op.decrement = 1'b1;
          if (slice_inc >= quantum_r) begin
            slice_nxt = '0;
            pos_nxt   = (CNT_W'(p) + CNT_ONE >= cnt_r) ? '0 : p + IDX_W'(1);
          end else begin
            slice_nxt = slice_inc;
            pos_nxt   = p;
          end
        end
      end
      res.active_count = cnt_ext[ACT_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
      cnt_r     <= '0;
      pos_r     <= '0;
      slice_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      slice_r <= slice_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("task count above table depth");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && CNT_W'(pos_r) < cnt_r) || (cnt_r == '0 && pos_r == '0))
    else $error("position outside the held tasks");

  a_finish_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.finished |=> cnt_r == $past(cnt_r) - CNT_ONE)
    else $error("finished task not removed");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.add_accepted |=> cnt_r == $past(cnt_r) + CNT_ONE)
    else $error("accepted add not stored");

endmodule

`default_nettype wire

// ===== rtl/round_robin_task_scheduler_core.sv =====
// Round-robin time-slice scheduler, top level.
// Channels: in_chan carries requests (action = tick or add, task_id,
// burst_length); out_chan returns one result per request (ran, ran_id,
// remaining_after, finished, add_accepted, active_count). Both are
// valid/ready; a transfer happens on a clock edge with valid and ready high.
// cfg_wr_en/cfg_wr_data write the 8-bit quantum; write only while idle.
// Throughput: one request per cycle while the receiver does not stall, set
// by the single pass from the request register through the control logic
// and task table update into the result register; the result is held there
// until the receiver takes it.
// Reset (rst_n low, synchronous): table empty, position and slice counter
// zero, quantum 4. Table contents are not cleared and need no clearing pass.
// When the receiver stalls, the result register holds and the request
// register keeps one further request; ready drops once both are full.
// Depends on rrts_pkg, rrts_ifs, rrts_sched_ctrl and rrts_task_table.
`default_nettype none

module round_robin_task_scheduler_core
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rrts_in_if.sink                   in_chan,
  rrts_out_if.source                out_chan,
  input  wire logic                 cfg_wr_en,
  input  wire logic [QUANTUM_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_TASKS);

  logic  in_vld_r;
  item_t item_r;
  logic  out_vld_r;
  res_t  res_r;
  logic  adv;
  logic  go;
  logic  in_take;

  tbl_op_t              op;
  logic [IDX_W-1:0]     rd_pos;
  logic [IDX_W-1:0]     tail;
  logic [TASK_ID_W-1:0] wr_id;
  logic [TIME_BITS-1:0] wr_rem;
  logic [TASK_ID_W-1:0] rd_id;
  logic [TIME_BITS-1:0] rd_rem;
  res_t                 res;

  assign adv           = !out_vld_r || out_chan.ready;
  assign go            = in_vld_r && adv;
  assign in_chan.ready = !in_vld_r || adv;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (go) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action       <= in_chan.action;
      item_r.task_id      <= in_chan.task_id;
      item_r.burst_length <= in_chan.burst_length;
    end
    if (go) begin
      res_r <= res;
    end
  end

  rrts_sched_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .item        (item_r),
    .rd_id       (rd_id),
    .rd_rem      (rd_rem),
    .op          (op),
    .rd_pos      (rd_pos),
    .tail        (tail),
    .wr_id       (wr_id),
    .wr_rem      (wr_rem),
    .res         (res)
  );

  rrts_task_table #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk    (clk),
    .op     (op),
    .rd_pos (rd_pos),
    .tail   (tail),
    .wr_id  (wr_id),
    .wr_rem (wr_rem),
    .rd_id  (rd_id),
    .rd_rem (rd_rem)
  );

  assign out_chan.valid           = out_vld_r;
  assign out_chan.ran             = res_r.ran;
  assign out_chan.ran_id          = res_r.ran_id;
  assign out_chan.remaining_after = res_r.remaining_after;
  assign out_chan.finished        = res_r.finished;
  assign out_chan.add_accepted    = res_r.add_accepted;
  assign out_chan.active_count    = res_r.active_count;

endmodule

`default_nettype wire
